FILE: src/flame_sensor_calibration_accumulator_unit_assert.svh
// Assertion macros shared by the flame sensor accumulator modules.
`ifndef FLAME_SENSOR_CALIBRATION_ACCUMULATOR_UNIT_ASSERT_SVH
`define FLAME_SENSOR_CALIBRATION_ACCUMULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSCA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FSCA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/fsca_pkg.sv
// Package with types, constants and the leaky average update of the accumulator.
`timescale 1ns / 1ps

package fsca_pkg;

	localparam int SMP_W = 8;
	localparam int AVG_W = 16;
	localparam int SIG_W = 10;
	localparam int SQ_W  = 18;
	localparam int SUM_W = 32;
	localparam int CNT_W = 11;

	localparam logic CMD_START  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	localparam logic [AVG_W-1:0]        AVG_RESET = 16'd17792;
	localparam logic [AVG_W-1:0]        AVG_MAX   = 16'd32895;
	localparam logic signed [SIG_W-1:0] HIGH_RESET = 10'sd0;
	localparam logic signed [SIG_W-1:0] LOW_RESET  = 10'sd255;
	localparam logic signed [SIG_W-1:0] SIG_MAX    = 10'sd383;
	localparam logic signed [SIG_W-1:0] SIG_MIN    = -10'sd383;
	localparam logic [SMP_W-1:0]        RT_RESET   = 8'd128;

	// Load strobes and item flags handed from the control unit to each lane.
	typedef struct packed {
		logic load1;
		logic take0;
		logic start0;
		logic load2;
		logic load3;
		logic take_s2;
		logic start_s2;
	} fsca_lane_ctl_t;

	// One x128 leaky average step: avg + floor((smp*128 - avg + rt) / 256).
	function automatic logic [AVG_W-1:0] leak(input logic [AVG_W-1:0] avg,
			input logic [SMP_W-1:0] smp, input logic [SMP_W-1:0] rt);
		logic signed [17:0] d;
		logic signed [17:0] n;
		d = $signed({3'b000, smp, 7'b0000000}) - $signed({2'b00, avg})
			+ $signed({10'b0, rt});
		n = $signed({2'b00, avg}) + (d >>> 8);
		return n[AVG_W-1:0];
	endfunction

endpackage

FILE: src/fsca_channels.sv
// Channel interfaces: input items, result items and the configuration write.
`timescale 1ns / 1ps

interface fsca_in_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] flame_a_sample;
	logic [7:0] flame_b_sample;
	logic [7:0] guard_sample;
	logic [7:0] bias_sample;

	modport source (output valid, cmd, flame_a_sample, flame_b_sample, guard_sample,
		bias_sample, input ready);
	modport sink (input valid, cmd, flame_a_sample, flame_b_sample, guard_sample,
		bias_sample, output ready);
endinterface

interface fsca_out_if;
	logic              valid;
	logic              ready;
	logic [31:0]       energy_a;
	logic [31:0]       energy_b;
	logic [31:0]       energy_g;
	logic signed [9:0] max_a;
	logic signed [9:0] min_a;
	logic signed [9:0] max_b;
	logic signed [9:0] min_b;
	logic signed [9:0] max_g;
	logic signed [9:0] min_g;
	logic [7:0]        bias_level;
	logic              run_done;

	modport source (output valid, energy_a, energy_b, energy_g, max_a, min_a, max_b,
		min_b, max_g, min_g, bias_level, run_done, input ready);
	modport sink (input valid, energy_a, energy_b, energy_g, max_a, min_a, max_b,
		min_b, max_g, min_g, bias_level, run_done, output ready);
endinterface

interface fsca_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] rounding_term;

	modport source (output valid, rounding_term, input ready);
	modport sink (input valid, rounding_term, output ready);
endinterface

FILE: src/fsca_lane.sv
// One sensor lane: leaky average, drift-corrected signal, square, peaks and energy.
`timescale 1ns / 1ps
`include "flame_sensor_calibration_accumulator_unit_assert.svh"

module fsca_lane import fsca_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fsca_lane_ctl_t          ctl,
	input  logic                    clr_on_start,
	input  logic [SMP_W-1:0]        rounding_term,
	input  logic [SMP_W-1:0]        sample,
	input  logic [SMP_W-1:0]        bias_s1,
	output logic signed [SIG_W-1:0] peak_high,
	output logic signed [SIG_W-1:0] peak_low,
	output logic [SUM_W-1:0]        energy
);

	logic [AVG_W-1:0]        avg_q;
	logic [AVG_W-1:0]        avg_nx;
	logic [AVG_W-1:0]        avg_s1;
	logic [SMP_W-1:0]        sample_s1;
	logic [AVG_W:0]          rnd;
	logic [SMP_W-1:0]        drift;
	logic signed [SIG_W-1:0] drift_x;
	logic signed [SIG_W-1:0] sig;
	logic signed [2*SIG_W-1:0] prod;
	logic signed [SIG_W-1:0] sig_s2;
	logic [SQ_W-1:0]         sq_s2;
	logic signed [SIG_W-1:0] peak_high_q;
	logic signed [SIG_W-1:0] peak_low_q;
	logic [SUM_W-1:0]        energy_q;
	logic [SUM_W:0]          sum_wide;

	// Stage 1: next leaky average; the guard lane reloads it on a start item.
	always_comb begin
		if (ctl.take0) begin
			avg_nx = leak(avg_q, sample, rounding_term);
		end else if (ctl.start0 && clr_on_start) begin
			avg_nx = AVG_RESET;
		end else begin
			avg_nx = avg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q <= AVG_RESET;
		end else if (ctl.load1) begin
			avg_q <= avg_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load1) begin
			avg_s1    <= avg_nx;
			sample_s1 <= sample;
		end
	end

	// Stage 2: drift is the rounded average minus bias, wrapped to 8 bits signed.
	always_comb begin
		rnd     = {1'b0, avg_s1} + 17'd64;
		drift   = rnd[14:7] - bias_s1;
		drift_x = {{(SIG_W-SMP_W){drift[SMP_W-1]}}, drift};
		sig     = $signed({2'b00, sample_s1}) - $signed({2'b00, bias_s1}) - drift_x;
		prod    = sig * sig;
	end

	always_ff @(posedge clk) begin
		if (ctl.load2) begin
			sig_s2 <= sig;
			sq_s2  <= prod[SQ_W-1:0];
		end
	end

	// Stage 3: saturating energy sum of squares.
	assign sum_wide = {1'b0, energy_q} + {{(SUM_W+1-SQ_W){1'b0}}, sq_s2};

	// Stage 3: peak tracking and energy; these registers also serve as the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_high_q <= HIGH_RESET;
			peak_low_q  <= LOW_RESET;
			energy_q    <= '0;
		end else if (ctl.load3) begin
			if (ctl.start_s2) begin
				peak_high_q <= HIGH_RESET;
				peak_low_q  <= LOW_RESET;
				energy_q    <= '0;
			end else if (ctl.take_s2) begin
				if (peak_high_q <= sig_s2) begin
					peak_high_q <= sig_s2;
				end else if (peak_low_q >= sig_s2) begin
					peak_low_q <= sig_s2;
				end
				energy_q <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
			end
		end
	end

	assign peak_high = peak_high_q;
	assign peak_low  = peak_low_q;
	assign energy    = energy_q;

	`FSCA_ASSERT_NOW(a_sig_range, clk, arst_n, ctl.take_s2, (sig_s2 >= SIG_MIN) && (sig_s2 <= SIG_MAX), "lane signal out of range")
	`FSCA_ASSERT_NEXT(a_energy_grows, clk, arst_n, ctl.load3 && ctl.take_s2 && !ctl.start_s2, energy_q >= $past(energy_q), "lane energy decreased on a sample")
	`FSCA_ASSERT_NEXT(a_one_peak, clk, arst_n, ctl.load3 && !ctl.start_s2, !((peak_high_q != $past(peak_high_q)) && (peak_low_q != $past(peak_low_q))), "both peaks changed on one sample")
	`FSCA_ASSERT_NOW(a_avg_range, clk, arst_n, 1'b1, avg_q <= AVG_MAX, "lane average out of range")

endmodule

FILE: src/fsca_ctrl.sv
// Control unit: pipeline handshake, sample count, bias average and configuration.
`timescale 1ns / 1ps
`include "flame_sensor_calibration_accumulator_unit_assert.svh"

module fsca_ctrl import fsca_pkg::*; #(
	parameter int RUN_LENGTH = 1020
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             cmd,
	input  logic [SMP_W-1:0] bias_sample,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [SMP_W-1:0] cfg_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [SMP_W-1:0] rounding_term,
	output logic [SMP_W-1:0] bias_s1,
	output fsca_lane_ctl_t   ctl,
	output logic [SMP_W-1:0] bias_level,
	output logic             run_done
);

	localparam logic [CNT_W-1:0] RUN_LEN_C = CNT_W'(RUN_LENGTH);

	logic             valid_s1, valid_s2, valid_s3;
	logic             rdy1, rdy2, rdy3;
	logic             load1, load2, load3;
	logic             take0, start0;
	logic             take_s1, start_s1, take_s2, start_s2;
	logic [CNT_W-1:0] count_q, count_nx;
	logic [AVG_W-1:0] avg_bias_q, avg_bias_nx;
	logic [AVG_W:0]   bias_rnd;
	logic             run_done_nx;
	logic [SMP_W-1:0] bias_level_s1, bias_level_s2, bias_level_s3;
	logic             run_done_s1, run_done_s2, run_done_s3;
	logic [SMP_W-1:0] rt_q;

	// Each stage moves when it is empty or the stage after it moves.
	always_comb begin
		rdy3     = !valid_s3 || out_ready;
		rdy2     = !valid_s2 || rdy3;
		rdy1     = !valid_s1 || rdy2;
		load3    = valid_s2 && rdy3;
		load2    = valid_s1 && rdy2;
		load1    = in_valid && rdy1;
		in_ready = rdy1;
		start0   = load1 && (cmd == CMD_START);
		take0    = load1 && (cmd == CMD_SAMPLE) && (count_q < RUN_LEN_C);
	end

	// Next sample count, bias average and the result fields they give.
	always_comb begin
		if (start0) begin
			count_nx = '0;
		end else if (take0) begin
			count_nx = count_q + 1'b1;
		end else begin
			count_nx = count_q;
		end
		avg_bias_nx = take0 ? leak(avg_bias_q, bias_sample, rt_q) : avg_bias_q;
		bias_rnd    = {1'b0, avg_bias_nx} + 17'd64;
		run_done_nx = (count_nx >= RUN_LEN_C);
	end

	// Configuration register; writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_q <= RT_RESET;
		end else if (cfg_valid) begin
			rt_q <= cfg_data;
		end
	end

	// Stage valid bits, item flags and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			valid_s3   <= 1'b0;
			take_s1    <= 1'b0;
			start_s1   <= 1'b0;
			take_s2    <= 1'b0;
			start_s2   <= 1'b0;
			count_q    <= '0;
			avg_bias_q <= AVG_RESET;
		end else begin
			if (rdy1) begin
				valid_s1 <= in_valid;
			end
			if (rdy2) begin
				valid_s2 <= valid_s1;
			end
			if (rdy3) begin
				valid_s3 <= valid_s2;
			end
			if (load1) begin
				take_s1    <= take0;
				start_s1   <= start0;
				count_q    <= count_nx;
				avg_bias_q <= avg_bias_nx;
			end
			if (load2) begin
				take_s2  <= take_s1;
				start_s2 <= start_s1;
			end
		end
	end

	// Shared payload that travels with the item.
	always_ff @(posedge clk) begin
		if (load1) begin
			bias_s1       <= bias_sample;
			bias_level_s1 <= bias_rnd[14:7];
			run_done_s1   <= run_done_nx;
		end
		if (load2) begin
			bias_level_s2 <= bias_level_s1;
			run_done_s2   <= run_done_s1;
		end
		if (load3) begin
			bias_level_s3 <= bias_level_s2;
			run_done_s3   <= run_done_s2;
		end
	end

	always_comb begin
		ctl.load1    = load1;
		ctl.take0    = take0;
		ctl.start0   = start0;
		ctl.load2    = load2;
		ctl.load3    = load3;
		ctl.take_s2  = take_s2;
		ctl.start_s2 = start_s2;
	end

	assign rounding_term = rt_q;
	assign out_valid     = valid_s3;
	assign bias_level    = bias_level_s3;
	assign run_done      = run_done_s3;

	`FSCA_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= RUN_LEN_C, "sample count beyond run length")
	`FSCA_ASSERT_NEXT(a_start_clears, clk, arst_n, start0, count_q == '0, "start item did not clear the count")
	`FSCA_ASSERT_NEXT(a_count_step, clk, arst_n, take0, count_q == $past(count_q) + 1'b1, "sample did not advance the count")
	`FSCA_ASSERT_NOW(a_bias_range, clk, arst_n, 1'b1, avg_bias_q <= AVG_MAX, "bias average out of range")

endmodule

FILE: src/flame_sensor_calibration_accumulator_unit.sv
// Top level of the flame sensor calibration accumulator: control unit, three lanes, result.
//
//   Channel   Direction  Transfer when         Contents
//   in_ch     sink       valid && ready        cmd and four 8-bit samples
//   cfg_ch    sink       valid && ready        rounding_term (ready is always high)
//   out_ch    source     valid && ready        three energies, six peaks, bias level, done
//
// One item enters per cycle unless a stalled output has filled all stages; its result is
// offered after stages 1, 2 and 3. The feedback loops are the leaky average registers
// in stage 1 and the peak and energy registers in stage 3, which also hold the result
// until it is taken. A stalled output stops each stage only once the stages behind it
// are full. Reset sets the averages to 17792, the peaks to 0 and 255, the rounding term
// to 128, and clears the rest.
`timescale 1ns / 1ps

module flame_sensor_calibration_accumulator_unit import fsca_pkg::*; #(
	parameter int RUN_LENGTH = 1020
) (
	input logic        clk,
	input logic        arst_n,
	fsca_in_if.sink    in_ch,
	fsca_cfg_if.sink   cfg_ch,
	fsca_out_if.source out_ch
);

	fsca_lane_ctl_t          ctl;
	logic [SMP_W-1:0]        rounding_term;
	logic [SMP_W-1:0]        bias_s1;
	logic signed [SIG_W-1:0] peak_high [3];
	logic signed [SIG_W-1:0] peak_low [3];
	logic [SUM_W-1:0]        energy [3];
	logic [SMP_W-1:0]        lane_sample [3];
	logic                    lane_clr [3];

	// Lane inputs: flame A, flame B, guard; only the guard average restarts with a run.
	always_comb begin
		lane_sample[0] = in_ch.flame_a_sample;
		lane_sample[1] = in_ch.flame_b_sample;
		lane_sample[2] = in_ch.guard_sample;
		lane_clr[0]    = 1'b0;
		lane_clr[1]    = 1'b0;
		lane_clr[2]    = 1'b1;
	end

	fsca_ctrl #(
		.RUN_LENGTH (RUN_LENGTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.cmd           (in_ch.cmd),
		.bias_sample   (in_ch.bias_sample),
		.cfg_valid     (cfg_ch.valid),
		.cfg_ready     (cfg_ch.ready),
		.cfg_data      (cfg_ch.rounding_term),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.rounding_term (rounding_term),
		.bias_s1       (bias_s1),
		.ctl           (ctl),
		.bias_level    (out_ch.bias_level),
		.run_done      (out_ch.run_done)
	);

	// Three instances of one lane module work on the three sensor channels side by side.
	for (genvar k = 0; k < 3; k++) begin : g_lane
		fsca_lane u_lane (
			.clk           (clk),
			.arst_n        (arst_n),
			.ctl           (ctl),
			.clr_on_start  (lane_clr[k]),
			.rounding_term (rounding_term),
			.sample        (lane_sample[k]),
			.bias_s1       (bias_s1),
			.peak_high     (peak_high[k]),
			.peak_low      (peak_low[k]),
			.energy        (energy[k])
		);
	end

	// Merge the lane registers into one result item.
	always_comb begin
		out_ch.energy_a = energy[0];
		out_ch.energy_b = energy[1];
		out_ch.energy_g = energy[2];
		out_ch.max_a    = peak_high[0];
		out_ch.min_a    = peak_low[0];
		out_ch.max_b    = peak_high[1];
		out_ch.min_b    = peak_low[1];
		out_ch.max_g    = peak_high[2];
		out_ch.min_g    = peak_low[2];
	end

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the flame sensor calibration accumulator unit.
`timescale 1ns / 1ps

module tb;
	import fsca_pkg::*;

	localparam int RUN_LEN = 1020;
	localparam int HOLD_LEN = 40;
	localparam int STALL_LIMIT = 2000;

	// One sensor sample set as offered on the input channel.
	typedef struct packed {
		logic       cmd;
		logic [7:0] smp_a;
		logic [7:0] smp_b;
		logic [7:0] smp_g;
		logic [7:0] bias;
	} sensor_set_t;

	// One calibration report: index 0 is flame A, 1 is flame B, 2 is guard.
	typedef struct {
		logic [31:0]       energy[3];
		logic signed [9:0] peak_hi[3];
		logic signed [9:0] peak_lo[3];
		logic [7:0]        bias_level;
		logic              run_done;
	} calib_report_t;

	// Tracks the calibration state and the reports still due from the block.
	class calib_tracker;
		logic [7:0]    rounding;
		logic [15:0]   avg_ch[3];
		logic [15:0]   avg_bias;
		int            peak_hi[3];
		int            peak_lo[3];
		bit [31:0]     energy[3];
		int            taken;
		int            mismatches;
		calib_report_t due_reports[$];

		function new();
			rounding = 8'd128;
			avg_bias = 16'd17792;
			for (int k = 0; k < 3; k++) begin
				avg_ch[k] = 16'd17792;
			end
			mismatches = 0;
			clear_run();
		endfunction

		function void clear_run();
			for (int k = 0; k < 3; k++) begin
				peak_hi[k] = 0;
				peak_lo[k] = 255;
				energy[k] = '0;
			end
			avg_ch[2] = 16'd17792;
			taken = 0;
		endfunction

		function void set_rounding(logic [7:0] v);
			rounding = v;
		endfunction

		// Leaky x128 average: the signed shift gives the floor of the division.
		function logic [15:0] leaky(logic [15:0] avg, logic [7:0] smp);
			int delta;
			int next_avg;
			delta = int'(smp) * 128 - int'(avg) + int'(rounding);
			next_avg = int'(avg) + (delta >>> 8);
			return next_avg[15:0];
		endfunction

		// Drift-corrected signal, peak tracking and saturating energy of one channel.
		function void fold_signal(int k, logic [7:0] smp, logic [7:0] bias);
			int     rounded;
			logic [7:0] drift_w;
			int     sig;
			longint total;
			rounded = (int'(avg_ch[k]) + 64) / 128;
			drift_w = 8'(rounded - int'(bias));
			sig = int'(smp) - int'(bias) - int'($signed(drift_w));
			if (peak_hi[k] <= sig) begin
				peak_hi[k] = sig;
			end else if (peak_lo[k] >= sig) begin
				peak_lo[k] = sig;
			end
			total = longint'(energy[k]) + longint'(sig * sig);
			energy[k] = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
		endfunction

		// Updates the state for an accepted set and queues the report it causes.
		function void note_set(sensor_set_t s);
			logic [7:0]    smp[3];
			calib_report_t r;
			smp[0] = s.smp_a;
			smp[1] = s.smp_b;
			smp[2] = s.smp_g;
			if (s.cmd == CMD_START) begin
				clear_run();
			end else if (taken < RUN_LEN) begin
				for (int k = 0; k < 3; k++) begin
					avg_ch[k] = leaky(avg_ch[k], smp[k]);
				end
				for (int k = 0; k < 3; k++) begin
					fold_signal(k, smp[k], s.bias);
				end
				avg_bias = leaky(avg_bias, s.bias);
				taken++;
			end
			for (int k = 0; k < 3; k++) begin
				r.energy[k] = energy[k];
				r.peak_hi[k] = 10'(peak_hi[k]);
				r.peak_lo[k] = 10'(peak_lo[k]);
			end
			r.bias_level = 8'((int'(avg_bias) + 64) / 128);
			r.run_done = (taken >= RUN_LEN);
			due_reports.push_back(r);
		endfunction

		function void compare_field(string name, logic signed [33:0] expv,
				logic signed [33:0] gotv);
			if (gotv !== expv) begin
				mismatches++;
				$error("%s: expected %0d, got %0d", name, expv, gotv);
			end
		endfunction

		// Compares a report taken from the block with the oldest one due.
		function void check_report(calib_report_t got);
			calib_report_t want;
			string         tag[3];
			tag[0] = "a";
			tag[1] = "b";
			tag[2] = "g";
			if (due_reports.size() == 0) begin
				mismatches++;
				$error("report transfer with no report due");
				return;
			end
			want = due_reports.pop_front();
			for (int k = 0; k < 3; k++) begin
				compare_field({"energy_", tag[k]}, want.energy[k], got.energy[k]);
				compare_field({"max_", tag[k]}, want.peak_hi[k], got.peak_hi[k]);
				compare_field({"min_", tag[k]}, want.peak_lo[k], got.peak_lo[k]);
			end
			compare_field("bias_level", want.bias_level, got.bias_level);
			compare_field("run_done", want.run_done, got.run_done);
		endfunction

		function int outstanding();
			return due_reports.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	bit   hold_request;

	calib_tracker tracker = new();

	fsca_in_if  in_ch();
	fsca_cfg_if cfg_ch();
	fsca_out_if out_ch();

	flame_sensor_calibration_accumulator_unit #(
		.RUN_LENGTH(RUN_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.cfg_ch(cfg_ch),
		.out_ch(out_ch)
	);

	// Clock generation.
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Values near the ends of the range come up more often than uniform draws give.
	function automatic logic [7:0] pick_byte();
		if ($urandom_range(7) == 0) begin
			return $urandom_range(1) ? 8'hFF : 8'h00;
		end
		return 8'($urandom_range(255));
	endfunction

	function automatic sensor_set_t pick_set(int start_pct, bit bias_high);
		sensor_set_t s;
		s.cmd = ($urandom_range(99) < start_pct) ? CMD_START : CMD_SAMPLE;
		s.smp_a = pick_byte();
		s.smp_b = pick_byte();
		s.smp_g = pick_byte();
		s.bias = bias_high ? 8'hFF : pick_byte();
		return s;
	endfunction

	// Offers one set on the input channel; called and left just after a rising edge.
	task automatic offer_set(sensor_set_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= s.cmd;
		in_ch.flame_a_sample <= s.smp_a;
		in_ch.flame_b_sample <= s.smp_b;
		in_ch.guard_sample <= s.smp_g;
		in_ch.bias_sample <= s.bias;
		@(negedge clk);
		while (!in_ch.ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		tracker.note_set(s);
	endtask

	task automatic offer_sample(logic [7:0] a, logic [7:0] b, logic [7:0] g,
			logic [7:0] bias);
		offer_set('{CMD_SAMPLE, a, b, g, bias});
	endtask

	task automatic offer_start();
		sensor_set_t s;
		s = pick_set(0, 1'b0);
		s.cmd = CMD_START;
		offer_set(s);
	endtask

	task automatic offer_random(int count, int start_pct, bit bias_high);
		for (int i = 0; i < count; i++) begin
			offer_set(pick_set(start_pct, bias_high));
		end
	endtask

	// Writes the rounding term once every due report has come back.
	task automatic write_rounding(logic [7:0] v);
		in_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.rounding_term <= v;
		@(negedge clk);
		while (!cfg_ch.ready) begin
			@(negedge clk);
		end
		@(posedge clk);
		cfg_ch.valid <= 1'b0;
		tracker.set_rounding(v);
	endtask

	// Report receiver: random stalls plus one long hold-off on request.
	initial begin
		int hold_left;
		hold_left = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_LEN - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Report monitor: the values seen here are the ones moved at the next rising edge.
	initial begin
		calib_report_t got;
		forever begin
			@(negedge clk);
			if (arst_n && out_ch.valid && out_ch.ready) begin
				got.energy[0] = out_ch.energy_a;
				got.energy[1] = out_ch.energy_b;
				got.energy[2] = out_ch.energy_g;
				got.peak_hi[0] = out_ch.max_a;
				got.peak_lo[0] = out_ch.min_a;
				got.peak_hi[1] = out_ch.max_b;
				got.peak_lo[1] = out_ch.min_b;
				got.peak_hi[2] = out_ch.max_g;
				got.peak_lo[2] = out_ch.min_g;
				got.bias_level = out_ch.bias_level;
				got.run_done = out_ch.run_done;
				tracker.check_report(got);
			end
		end
	end

	// Watchdog: ends the run after too many cycles without any transfer.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(negedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready) || !arst_n) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("[flame_sensor_calibration_accumulator_unit] ERROR");
		$finish;
	end

	// Main sequence: reset, directed sets, then three random phases.
	initial begin
		arst_n = 1'b0;
		hold_request = 1'b0;
		send_idle_pct = 33;
		recv_idle_pct = 54;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_SAMPLE;
		in_ch.flame_a_sample = '0;
		in_ch.flame_b_sample = '0;
		in_ch.guard_sample = '0;
		in_ch.bias_sample = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.rounding_term = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets at the reset rounding term: extremes, starts, equal signals.
		offer_start();
		offer_sample(8'h00, 8'h00, 8'h00, 8'h00);
		offer_sample(8'hFF, 8'hFF, 8'hFF, 8'hFF);
		offer_sample(8'hFF, 8'hFF, 8'hFF, 8'h00);
		offer_sample(8'h00, 8'h00, 8'h00, 8'hFF);
		offer_sample(8'hFF, 8'h00, 8'h80, 8'h00);
		offer_sample(8'h00, 8'hFF, 8'h7F, 8'hFF);
		offer_sample(8'hAA, 8'h55, 8'hAA, 8'h55);
		offer_sample(8'h55, 8'hAA, 8'h55, 8'hAA);
		offer_start();
		offer_start();
		offer_sample(8'h80, 8'h80, 8'h80, 8'h80);
		offer_sample(8'h80, 8'h80, 8'h80, 8'h80);
		offer_sample(8'h80, 8'h80, 8'h80, 8'h80);
		offer_sample(8'h01, 8'hFE, 8'h01, 8'hFE);
		offer_sample(8'hFE, 8'h01, 8'hFE, 8'h01);
		offer_start();
		offer_sample(8'h00, 8'hFF, 8'h00, 8'h80);
		offer_sample(8'hFF, 8'h00, 8'hFF, 8'h80);
		offer_sample(8'h7F, 8'h80, 8'h01, 8'hFE);

		// Phase 1: zero rounding term, short runs with frequent starts.
		write_rounding(8'h00);
		offer_random(150, 3, 1'b0);

		// Phase 2: full rounding term, one run past its length with a pinned-high bias first.
		write_rounding(8'hFF);
		send_idle_pct = 54;
		recv_idle_pct = 33;
		offer_start();
		offer_random(400, 0, 1'b1);
		offer_random(650, 0, 1'b0);

		// Phase 3: random rounding term, no idling, and a long receiver hold-off.
		write_rounding(8'($urandom_range(1, 254)));
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request = 1'b1;
		offer_random(100, 5, 1'b0);

		in_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) begin
			@(posedge clk);
		end
		repeat (10) @(posedge clk);
		if (tracker.mismatches == 0) begin
			$display("[flame_sensor_calibration_accumulator_unit] OK");
		end else begin
			$display("[flame_sensor_calibration_accumulator_unit] ERROR");
		end
		$finish;
	end

endmodule
